// ----- rtl/serg_pkg.sv -----
// serg_pkg: shared types for the shuffle-exchange route generator
// word formats of the request and response channels and the sequencer states
// no dependencies
package serg_pkg;

   typedef struct packed {
      logic [15:0] source_node;
      logic [15:0] dest_node;
   } serg_req_type;

   typedef struct packed {
      logic [15:0] path_node;
      logic        path_last;
   } serg_rsp_type;

   typedef enum logic [1:0] {
      SERG_IDLE,
      SERG_SOURCE,
      SERG_EXCHANGE,
      SERG_SHUFFLE
   } serg_state_type;

endpackage

// ----- rtl/serg_queue.sv -----
// serg_queue: two-entry queue between the request front and the route sequencer
// depends on nothing; WIDTH sets the entry size
module serg_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/serg_front.sv -----
// serg_front: accepts request words, trims node indexes and flags trivial routes
// depends on serg_pkg
module serg_front
   import serg_pkg::*;
#(
   parameter int NODE_BITS = 16
) (
   input  logic                   start,
   output logic                   busy,
   input  serg_req_type           req_word,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [2*NODE_BITS:0]   q_data
);

   logic [NODE_BITS-1:0] src;
   logic [NODE_BITS-1:0] dst;
   logic                 same;

   assign src    = NODE_BITS'(req_word.source_node);
   assign dst    = NODE_BITS'(req_word.dest_node);
   assign same   = (src == dst);
   assign busy   = q_full;
   assign q_push = start && !q_full;
   assign q_data = {src, dst, same};

endmodule

// ----- rtl/serg_back.sv -----
// serg_back: route sequencer, one exchange or shuffle step per cycle
// depends on serg_pkg; takes routes from serg_queue
module serg_back
   import serg_pkg::*;
#(
   parameter int NODE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  logic [2*NODE_BITS:0] q_data,
   output logic                 q_pop,
   output logic                 rsp_strobe,
   output serg_rsp_type         rsp_word
);

   localparam int POS_W = $clog2(NODE_BITS);

   serg_state_type       state_ff, state_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [NODE_BITS-1:0] dst_ff, dst_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 same_ff, same_in;
   logic                 strobe_ff, strobe_in;
   serg_rsp_type         rsp_ff, rsp_in;

   logic [NODE_BITS-1:0] xnode, rnode, out_node;
   logic                 emit, last;

   assign xnode = {node_ff[NODE_BITS-1:1], ~node_ff[0]};
   assign rnode = {node_ff[NODE_BITS-2:0], node_ff[NODE_BITS-1]};

   // step outputs
   always_comb begin
      emit     = 1'b0;
      last     = 1'b0;
      out_node = node_ff;
      q_pop    = 1'b0;
      case (state_ff)
         SERG_IDLE: begin
            q_pop = q_valid;
         end
         SERG_SOURCE: begin
            emit = 1'b1;
            last = same_ff;
         end
         SERG_EXCHANGE: begin
            emit     = (node_ff[0] != dst_ff[pos_ff]);
            out_node = xnode;
            last     = (xnode == dst_ff);
         end
         SERG_SHUFFLE: begin
            emit     = (rnode != node_ff);
            out_node = rnode;
            last     = (rnode == dst_ff);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SERG_IDLE: begin
            if (q_valid) state_in = SERG_SOURCE;
         end
         SERG_SOURCE: begin
            state_in = same_ff ? SERG_IDLE : SERG_EXCHANGE;
         end
         SERG_EXCHANGE: begin
            state_in = (emit && last) ? SERG_IDLE : SERG_SHUFFLE;
         end
         SERG_SHUFFLE: begin
            if ((emit && last) || pos_ff == '0) begin
               state_in = SERG_IDLE;
            end else begin
               state_in = SERG_EXCHANGE;
            end
         end
         default: begin
            state_in = SERG_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      node_in   = node_ff;
      dst_in    = dst_ff;
      pos_in    = pos_ff;
      same_in   = same_ff;
      strobe_in = emit;
      rsp_in.path_node = 16'(out_node);
      rsp_in.path_last = last;
      case (state_ff)
         SERG_IDLE: begin
            if (q_valid) begin
               node_in = q_data[2*NODE_BITS:NODE_BITS+1];
               dst_in  = q_data[NODE_BITS:1];
               same_in = q_data[0];
            end
         end
         SERG_SOURCE: begin
            pos_in = POS_W'(NODE_BITS - 1);
         end
         SERG_EXCHANGE: begin
            if (emit) node_in = xnode;
         end
         SERG_SHUFFLE: begin
            if (emit) node_in = rnode;
            if (pos_ff != '0) pos_in = pos_ff - POS_W'(1);
         end
         default: begin
            node_in = node_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      dst_ff  <= dst_in;
      pos_ff  <= pos_in;
      same_ff <= same_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SERG_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- rtl/shuffle_exchange_route_generator_unit.sv -----
// shuffle_exchange_route_generator_unit: route generator top level
// first node leaves via the queue, the idle and source states and the output register;
// then at most one node per step, the sequencer alternating exchange and shuffle steps
// two route words queue behind the sequencer; busy rises when both slots are taken
// synchronous reset empties the queue and idles the sequencer; no strobe during reset
// depends on serg_pkg, serg_front, serg_queue, serg_back
module shuffle_exchange_route_generator_unit
   import serg_pkg::*;
#(
   parameter int NODE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  serg_req_type req_word,
   output logic         rsp_strobe,
   output serg_rsp_type rsp_word
);

   localparam int QW = 2 * NODE_BITS + 1;

   logic          q_full, q_push, q_pop, q_valid;
   logic [QW-1:0] q_in_data, q_out_data;

   serg_front #(.NODE_BITS(NODE_BITS)) u_front (
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   serg_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out_data)
   );

   serg_back #(.NODE_BITS(NODE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_out_data),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
